[rtl/rvd_pkg.sv]
// Shared types, constants and codes of the video payload depacketizer.
`default_nettype none
package rvd_pkg;

	localparam int ADDR_W      = 26;
	localparam int PLEN_W      = 14;
	localparam int LINES_W     = 2;
	localparam int LT_DEPTH    = 3;
	localparam int HDR_IDX_W   = 3;
	localparam int PADDR_W     = 5;
	localparam int TGT_W       = 35;

	localparam logic [LINES_W-1:0]   MAX_LINES   = 2'd3;
	localparam logic [PLEN_W-1:0]    MAX_PAYLOAD = 14'd16383;
	localparam logic [PLEN_W-1:0]    SHORT_LEN   = 14'd8;
	localparam logic [HDR_IDX_W-1:0] ESN_LAST    = 3'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST    = 3'd5;

	// packet status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_LINES = 3'd2;
	localparam logic [2:0] ST_FIELD = 3'd3;
	localparam logic [2:0] ST_PKT   = 3'd4;
	localparam logic [2:0] ST_FRAME = 3'd5;

	// register word indexes
	localparam logic [2:0] REG_DECODE_ENABLE = 3'd0;
	localparam logic [2:0] REG_WIDTH_PIXELS  = 3'd1;
	localparam logic [2:0] REG_HEIGHT_LINES  = 3'd2;
	localparam logic [2:0] REG_INTERLACED    = 3'd3;
	localparam logic [2:0] REG_SMP_PER_PIX   = 3'd4;
	localparam logic [2:0] REG_BIT_DEPTH     = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ESN,
		PH_HEADER,
		PH_DATA,
		PH_DROP
	} phase_t;

	typedef struct packed {
		logic [7:0]        payload_byte;
		logic              first_byte;
		logic              last_byte;
		logic [PLEN_W-1:0] payload_length;
		logic [31:0]       rtp_timestamp;
		logic [15:0]       rtp_sequence;
	} in_item_t;

	typedef struct packed {
		logic              write_enable;
		logic [ADDR_W-1:0] write_address;
		logic [7:0]        write_data;
		logic              frame_start;
		logic [31:0]       frames_total;
		logic              packet_end;
		logic [31:0]       full_sequence;
		logic [2:0]        status;
		logic [14:0]       top_line;
	} out_item_t;

	typedef struct packed {
		logic        decode_enable;
		logic [13:0] width_pixels;
		logic [12:0] height_lines;
		logic        interlaced;
		logic [2:0]  smp_per_pix;
		logic [4:0]  bit_depth;
	} cfg_t;

	typedef struct packed {
		logic       take;
		phase_t     ph0;
		logic       fin_hdr;
		logic       cur_clr;
		logic       cur_inc;
		logic       err_set;
		logic [2:0] err_code;
		logic       bl_load;
		logic       emit;
		logic       emit_hold;
		phase_t     ph_final;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic short_pkt;
		logic decode_en;
		logic esn_done;
		logic hdr_done;
		logic field_err;
		logic too_many;
		logic cont_more;
		logic line_end;
		logic bl_more;
		logic bl_err4;
		logic bl_err5;
		logic bl_zero;
	} sts_t;

endpackage
`default_nettype wire

[rtl/rvd_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none
module rvd_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rvd_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output rvd_pkg::cfg_t                cfg
);

	rvd_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign pready = 1'b1;
	assign idx    = paddr[rvd_pkg::PADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// write on the access phase of a write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decode_enable <= 1'b1;
			cfg_q.width_pixels  <= 14'd1920;
			cfg_q.height_lines  <= 13'd1080;
			cfg_q.interlaced    <= 1'b0;
			cfg_q.smp_per_pix   <= 3'd2;
			cfg_q.bit_depth     <= 5'd10;
		end else if (wr) begin
			unique case (idx)
				rvd_pkg::REG_DECODE_ENABLE: cfg_q.decode_enable <= pwdata[0];
				rvd_pkg::REG_WIDTH_PIXELS:  cfg_q.width_pixels  <= pwdata[13:0];
				rvd_pkg::REG_HEIGHT_LINES:  cfg_q.height_lines  <= pwdata[12:0];
				rvd_pkg::REG_INTERLACED:    cfg_q.interlaced    <= pwdata[0];
				rvd_pkg::REG_SMP_PER_PIX:   cfg_q.smp_per_pix   <= pwdata[2:0];
				rvd_pkg::REG_BIT_DEPTH:     cfg_q.bit_depth     <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			rvd_pkg::REG_DECODE_ENABLE: prdata = {31'd0, cfg_q.decode_enable};
			rvd_pkg::REG_WIDTH_PIXELS:  prdata = {18'd0, cfg_q.width_pixels};
			rvd_pkg::REG_HEIGHT_LINES:  prdata = {19'd0, cfg_q.height_lines};
			rvd_pkg::REG_INTERLACED:    prdata = {31'd0, cfg_q.interlaced};
			rvd_pkg::REG_SMP_PER_PIX:   prdata = {29'd0, cfg_q.smp_per_pix};
			rvd_pkg::REG_BIT_DEPTH:     prdata = {27'd0, cfg_q.bit_depth};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/rvd_dp.sv]
// Datapath: packet counters, header capture, line table, line address unit, result register.
`default_nettype none
module rvd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rvd_pkg::cfg_t       cfg,
	input  rvd_pkg::in_item_t   item,
	input  rvd_pkg::cmd_t       cmd,
	output rvd_pkg::sts_t       sts,
	output rvd_pkg::out_item_t  result
);

	// control-side registers
	logic [rvd_pkg::HDR_IDX_W-1:0] idx_q;
	logic [rvd_pkg::LINES_W-1:0]   lines_q, cur_q;
	logic [rvd_pkg::PLEN_W-1:0]    cons_q, plen_q;
	logic [15:0]                   seq_q, esn_q, bl_q;
	logic [rvd_pkg::ADDR_W-1:0]    wptr_q;
	logic [31:0]                   last_ts_q, frames_q;
	logic                          seen_q;
	logic [14:0]                   highest_q;
	logic [2:0]                    perr_q;

	// payload registers
	logic [7:0]  hdr_q [5];
	logic [15:0] lt_len_q [rvd_pkg::LT_DEPTH];
	logic [14:0] lt_line_q [rvd_pkg::LT_DEPTH];
	logic [14:0] lt_off_q [rvd_pkg::LT_DEPTH];
	logic [7:0]  spd_s1;
	logic [18:0] lb_s2;
	logic [19:0] offb_s2;
	logic [rvd_pkg::TGT_W-1:0] tgt_s3;
	logic [31:0] buf_s3;
	logic        hold_we_q, hold_nf_q, hold_pe_q;
	logic [rvd_pkg::ADDR_W-1:0] hold_addr_q;
	logic [7:0]  hold_data_q;
	rvd_pkg::out_item_t result_q;

	logic                          first_t, active, wr, new_frm, hdr_ok, pe;
	logic [rvd_pkg::HDR_IDX_W-1:0] idx_b;
	logic [rvd_pkg::LINES_W-1:0]   lines_b, cur_sel;
	logic [rvd_pkg::PLEN_W-1:0]    cons_b, cons_nx, plen_nx, remaining;
	logic [15:0]                   seq_nx, esn_b, esn_nx, bl_dec, h_len, cur_len;
	logic [14:0]                   h_line, h_off, highest_nx;
	logic [31:0]                   frames_nx;
	logic [2:0]                    perr_b, perr_nx, final_err;
	logic [21:0]                   lb_prod;
	logic [22:0]                   off_prod;
	logic [33:0]                   line_prod;
	logic [12:0]                   h_eff;
	logic [rvd_pkg::TGT_W:0]       tgt_end;
	rvd_pkg::out_item_t            res_c;

	// per-item values after the first-byte restart
	assign first_t = cmd.take && item.first_byte;
	assign idx_b   = first_t ? '0 : idx_q;
	assign lines_b = first_t ? '0 : lines_q;
	assign cons_b  = first_t ? '0 : cons_q;
	assign plen_nx = first_t ? item.payload_length : plen_q;
	assign seq_nx  = first_t ? item.rtp_sequence : seq_q;
	assign active  = cmd.take && (cmd.ph0 != rvd_pkg::PH_IDLE);
	assign cons_nx = (active && cons_b < rvd_pkg::MAX_PAYLOAD) ? cons_b + 1'b1 : cons_b;
	assign wr      = cmd.take && (cmd.ph0 == rvd_pkg::PH_DATA);

	// line header fields, last byte taken straight from the input
	assign h_len  = {hdr_q[0], hdr_q[1]};
	assign h_line = {hdr_q[2][6:0], hdr_q[3]};
	assign h_off  = {hdr_q[4][6:0], item.payload_byte};

	assign esn_b  = first_t ? 16'd0 : esn_q;
	assign esn_nx = (cmd.take && cmd.ph0 == rvd_pkg::PH_ESN) ? {esn_b[7:0], item.payload_byte}
		: esn_b;

	// frame detection on timestamp change
	assign new_frm   = first_t && seen_q && (item.rtp_timestamp != last_ts_q);
	assign frames_nx = frames_q + {31'd0, new_frm};

	assign hdr_ok     = cmd.take && cmd.ph0 == rvd_pkg::PH_HEADER && sts.hdr_done && !sts.field_err;
	assign highest_nx = (hdr_ok && h_line > highest_q) ? h_line : highest_q;

	assign perr_b  = first_t ? ((item.payload_length < rvd_pkg::SHORT_LEN) ? rvd_pkg::ST_SHORT
		: rvd_pkg::ST_OK) : perr_q;
	assign perr_nx = cmd.err_set ? cmd.err_code : perr_b;

	assign bl_dec = (bl_q != 16'd0) ? bl_q - 1'b1 : 16'd0;

	// line address unit: table entry of the current line
	assign cur_sel   = (cur_q == rvd_pkg::MAX_LINES) ? '0 : cur_q;
	assign cur_len   = lt_len_q[cur_sel];
	assign remaining = (plen_q > cons_q) ? plen_q - cons_q : '0;
	assign lb_prod   = {8'd0, cfg.width_pixels} * {14'd0, spd_s1};
	assign off_prod  = {8'd0, lt_off_q[cur_sel]} * {15'd0, spd_s1};
	assign line_prod = {15'd0, lb_s2} * {19'd0, lt_line_q[cur_sel]};
	assign h_eff     = cfg.interlaced ? {1'b0, cfg.height_lines[12:1]} : cfg.height_lines;
	assign tgt_end   = {1'b0, tgt_s3} + {20'd0, cur_len};

	// status towards the controller
	always_comb begin
		sts.first     = item.first_byte;
		sts.last      = item.last_byte;
		sts.short_pkt = item.payload_length < rvd_pkg::SHORT_LEN;
		sts.decode_en = cfg.decode_enable;
		sts.esn_done  = idx_b == rvd_pkg::ESN_LAST;
		sts.hdr_done  = idx_b == rvd_pkg::HDR_LAST;
		sts.field_err = hdr_q[2][7] && !cfg.interlaced;
		sts.too_many  = lines_b >= rvd_pkg::MAX_LINES;
		sts.cont_more = hdr_q[4][7] && (cons_nx < plen_nx);
		sts.line_end  = bl_dec == 16'd0;
		sts.bl_more   = cur_q < lines_q;
		sts.bl_err4   = cur_len > {2'd0, remaining};
		sts.bl_err5   = tgt_end > {4'd0, buf_s3};
		sts.bl_zero   = cur_len == 16'd0;
	end

	// assemble the result, closing the packet on its last byte
	always_comb begin
		pe = cmd.emit_hold ? hold_pe_q : (active && item.last_byte);
		final_err = (perr_nx == rvd_pkg::ST_OK && (cmd.ph_final == rvd_pkg::PH_ESN ||
			cmd.ph_final == rvd_pkg::PH_HEADER || cmd.ph_final == rvd_pkg::PH_DATA))
			? rvd_pkg::ST_PKT : perr_nx;
		res_c.write_enable  = cmd.emit_hold ? hold_we_q : wr;
		res_c.write_address = cmd.emit_hold ? hold_addr_q : (wr ? wptr_q : '0);
		res_c.write_data    = cmd.emit_hold ? hold_data_q : (wr ? item.payload_byte : 8'd0);
		res_c.frame_start   = cmd.emit_hold ? hold_nf_q : new_frm;
		res_c.frames_total  = frames_nx;
		res_c.packet_end    = pe;
		res_c.status        = pe ? final_err : rvd_pkg::ST_OK;
		res_c.full_sequence = (pe && final_err != rvd_pkg::ST_SHORT) ? {esn_nx, seq_nx} : 32'd0;
		res_c.top_line      = highest_nx;
	end

	assign result = result_q;

	// packet and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			lines_q   <= '0;
			cur_q     <= '0;
			cons_q    <= '0;
			plen_q    <= '0;
			seq_q     <= '0;
			esn_q     <= '0;
			bl_q      <= '0;
			wptr_q    <= '0;
			last_ts_q <= '0;
			frames_q  <= '0;
			seen_q    <= 1'b0;
			highest_q <= '0;
			perr_q    <= '0;
		end else begin
			if (cmd.take) begin
				case (cmd.ph0)
					rvd_pkg::PH_ESN:    idx_q <= sts.esn_done ? '0 : idx_b + 1'b1;
					rvd_pkg::PH_HEADER: idx_q <= sts.hdr_done ? '0 : idx_b + 1'b1;
					default:            idx_q <= idx_b;
				endcase
				lines_q <= cmd.fin_hdr ? lines_b + 1'b1 : lines_b;
				cons_q  <= cons_nx;
			end
			if (cmd.cur_clr || first_t)
				cur_q <= '0;
			else if (cmd.cur_inc)
				cur_q <= cur_q + 1'b1;
			if (first_t)
				bl_q <= '0;
			else if (cmd.bl_load)
				bl_q <= cur_len;
			else if (wr)
				bl_q <= bl_dec;
			if (cmd.bl_load)
				wptr_q <= tgt_s3[rvd_pkg::ADDR_W-1:0];
			else if (wr)
				wptr_q <= wptr_q + 1'b1;
			if (first_t) begin
				seen_q    <= 1'b1;
				last_ts_q <= item.rtp_timestamp;
			end
			plen_q    <= plen_nx;
			seq_q     <= seq_nx;
			esn_q     <= esn_nx;
			frames_q  <= frames_nx;
			highest_q <= highest_nx;
			perr_q    <= perr_nx;
		end
	end

	// header bytes, line table, address stages, held result and output register
	always_ff @(posedge clk) begin
		if (cmd.take && cmd.ph0 == rvd_pkg::PH_HEADER && idx_b < rvd_pkg::HDR_LAST)
			hdr_q[idx_b] <= item.payload_byte;
		if (cmd.fin_hdr) begin
			lt_len_q[lines_b]  <= h_len;
			lt_line_q[lines_b] <= h_line;
			lt_off_q[lines_b]  <= h_off;
		end
		spd_s1  <= {5'd0, cfg.smp_per_pix} * {3'd0, cfg.bit_depth};
		lb_s2   <= lb_prod[21:3];
		offb_s2 <= off_prod[22:3];
		tgt_s3  <= {1'b0, line_prod} + {15'd0, offb_s2};
		buf_s3  <= {19'd0, h_eff} * {13'd0, lb_s2};
		if (cmd.take) begin
			hold_we_q   <= wr;
			hold_addr_q <= wr ? wptr_q : '0;
			hold_data_q <= wr ? item.payload_byte : 8'd0;
			hold_nf_q   <= new_frm;
			hold_pe_q   <= item.last_byte;
		end
		if (cmd.emit)
			result_q <= res_c;
	end

endmodule
`default_nettype wire

[rtl/rvd_ctrl.sv]
// Controller: packet parse phase, line-start sequencing and result handshake.
`default_nettype none
module rvd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  logic          result_ready,
	input  rvd_pkg::sts_t sts,
	output rvd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_RUN,
		S_BL_A,
		S_BL_B,
		S_BL_C,
		S_EMIT
	} state_t;

	state_t            state_q;
	rvd_pkg::phase_t   phase_q, ph0, ph1, bl_ph;
	logic              last_q, ov_q;
	logic              out_free, take, need_bl, fin, clr, inc_run, err_run, bl_loop, bl_ok;
	logic [2:0]        code_run, code_bl;
	logic              err_bl;

	assign out_free     = !ov_q || result_ready;
	assign item_ready   = (state_q == S_RUN) && out_free;
	assign take         = item_valid && item_ready;
	assign result_valid = ov_q;

	// phase step for an accepted byte
	always_comb begin
		ph0 = sts.first ? (sts.short_pkt ? rvd_pkg::PH_DROP : rvd_pkg::PH_ESN) : phase_q;
		ph1      = ph0;
		need_bl  = 1'b0;
		fin      = 1'b0;
		clr      = 1'b0;
		inc_run  = 1'b0;
		err_run  = 1'b0;
		code_run = rvd_pkg::ST_OK;
		unique case (ph0)
			rvd_pkg::PH_ESN: begin
				if (sts.esn_done)
					ph1 = sts.decode_en ? rvd_pkg::PH_HEADER : rvd_pkg::PH_DROP;
			end
			rvd_pkg::PH_HEADER: begin
				if (sts.hdr_done) begin
					if (sts.field_err) begin
						err_run  = 1'b1;
						code_run = rvd_pkg::ST_FIELD;
						ph1      = rvd_pkg::PH_DROP;
					end else if (sts.too_many) begin
						err_run  = 1'b1;
						code_run = rvd_pkg::ST_LINES;
						ph1      = rvd_pkg::PH_DROP;
					end else begin
						fin = 1'b1;
						if (!sts.cont_more) begin
							clr     = 1'b1;
							need_bl = 1'b1;
						end
					end
				end
			end
			rvd_pkg::PH_DATA: begin
				if (sts.line_end) begin
					inc_run = 1'b1;
					need_bl = 1'b1;
				end
			end
			rvd_pkg::PH_IDLE, rvd_pkg::PH_DROP: ;
			default: ;
		endcase
	end

	// line start outcome
	always_comb begin
		bl_ph   = rvd_pkg::PH_DROP;
		bl_loop = 1'b0;
		bl_ok   = 1'b0;
		err_bl  = 1'b0;
		code_bl = rvd_pkg::ST_OK;
		if (!sts.bl_more) begin
			bl_ph = rvd_pkg::PH_DROP;
		end else if (sts.bl_err4) begin
			err_bl  = 1'b1;
			code_bl = rvd_pkg::ST_PKT;
		end else if (sts.bl_err5) begin
			err_bl  = 1'b1;
			code_bl = rvd_pkg::ST_FRAME;
		end else if (sts.bl_zero) begin
			bl_loop = 1'b1;
		end else begin
			bl_ok = 1'b1;
			bl_ph = rvd_pkg::PH_DATA;
		end
	end

	// commands to the datapath
	always_comb begin
		cmd.take      = take;
		cmd.ph0       = ph0;
		cmd.fin_hdr   = take && fin;
		cmd.cur_clr   = take && clr;
		cmd.cur_inc   = (take && inc_run) || (state_q == S_BL_C && bl_loop);
		cmd.err_set   = (take && err_run) || (state_q == S_BL_C && err_bl);
		cmd.err_code  = (state_q == S_BL_C) ? code_bl : code_run;
		cmd.bl_load   = (state_q == S_BL_C) && bl_ok;
		cmd.emit      = (take && !need_bl) || (state_q == S_EMIT && out_free);
		cmd.emit_hold = state_q == S_EMIT;
		cmd.ph_final  = (state_q == S_EMIT) ? phase_q : ph1;
	end

	// sequencer, parse phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			phase_q <= rvd_pkg::PH_IDLE;
			last_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_RUN: begin
					if (take) begin
						if (need_bl) begin
							state_q <= S_BL_A;
							last_q  <= sts.last;
							phase_q <= ph1;
						end else if (sts.last && ph0 != rvd_pkg::PH_IDLE) begin
							phase_q <= rvd_pkg::PH_IDLE;
						end else begin
							phase_q <= ph1;
						end
					end
				end
				S_BL_A: state_q <= S_BL_B;
				S_BL_B: state_q <= S_BL_C;
				S_BL_C: begin
					if (bl_loop) begin
						state_q <= S_BL_A;
					end else begin
						phase_q <= bl_ph;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_RUN;
						if (last_q)
							phase_q <= rvd_pkg::PH_IDLE;
					end
				end
				default: state_q <= S_RUN;
			endcase
			if (cmd.emit)
				ov_q <= 1'b1;
			else if (result_ready)
				ov_q <= 1'b0;
		end
	end

	// the address stages always run their full length
	a_bl_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BL_A |=> state_q == S_BL_B)
		else $error("line start sequence skipped a stage");

	// a result never overwrites one still waiting
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!ov_q || result_ready))
		else $error("result register overrun");

	// a closed packet leaves the parser idle
	a_close_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !need_bl && sts.last && ph0 != rvd_pkg::PH_IDLE) |=>
		phase_q == rvd_pkg::PH_IDLE)
		else $error("parser not idle after packet end");

	// a held result is handed over once the output is free, then S_RUN resumes
	a_hold_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> (state_q == S_RUN && ov_q))
		else $error("held result not delivered");

endmodule
`default_nettype wire

[rtl/rfc4175_video_depacketizer.sv]
// Top level of the uncompressed video payload depacketizer.
// Takes one RTP payload byte per transaction and returns one result per byte.
// Each time a line starts (after the last line header of a packet and when a
// line's data runs out) the input stalls while the controller steps through
// S_BL_A, S_BL_B (the multiply stages of the line address unit), S_BL_C (bounds
// check) and S_EMIT (held result out); a zero-length line goes back to S_BL_A.
// A result register parts the two sides, so a new byte is taken in the same
// cycle as a pending result leaves.
`default_nettype none
module rfc4175_video_depacketizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  rvd_pkg::in_item_t           item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output rvd_pkg::out_item_t          result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rvd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	rvd_pkg::cfg_t cfg;
	rvd_pkg::cmd_t cmd;
	rvd_pkg::sts_t sts;

	rvd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rvd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	rvd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
`default_nettype wire

[tb/sv/tb_rfc4175_video_depacketizer.sv]
// Testbench of the video payload depacketizer: random packets checked against a predictor.
`timescale 1ns / 1ps
module tb_rfc4175_video_depacketizer;

	// kinds of generated packet
	localparam int K_OK       = 0;
	localparam int K_SHORT    = 1;
	localparam int K_FIELD    = 2;
	localparam int K_MANY     = 3;
	localparam int K_TRUNC    = 4;
	localparam int K_LONGLINE = 5;
	localparam int K_PASTFRM  = 6;
	localparam int K_STRAY    = 7;
	localparam int ITEM_GOAL  = 1050;
	localparam int LONG_HOLD  = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	rvd_pkg::in_item_t  item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	rvd_pkg::out_item_t result;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rvd_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	rvd_pkg::in_item_t  byte_q[$];
	rvd_pkg::out_item_t beat_q[$];
	int        fails = 0;
	int        pushed = 0;
	bit        in_taken = 0, out_taken = 0;
	int        tx_gap = 0, rx_gap = 0, rx_hold = 0;
	bit        tx_burst = 0, rx_burst = 0;
	bit        hold_req = 0;

	// shadow of the configuration registers
	int unsigned c_en, c_w, c_h, c_il, c_spp, c_dep;

	// shadow of the depacketizer state
	rvd_pkg::phase_t s_ph;
	int unsigned s_hidx, s_cons, s_esn, s_lines, s_cur, s_left, s_high, s_err, s_plen, s_seq;
	logic [rvd_pkg::ADDR_W-1:0] s_wp;
	logic [31:0] s_lts, s_frames;
	bit          s_tsseen;
	logic [7:0]  s_hdr[6];
	int unsigned lt_len[3], lt_line[3], lt_off[3];

	logic [31:0] ts_cur = 32'h1000;

	rfc4175_video_depacketizer DUT (.*);

	always #6 clk = ~clk;

	function automatic longint unsigned bytes_per_line();
		return (longint'(c_w) * c_spp * c_dep) >> 3;
	endfunction

	function automatic longint unsigned frame_size();
		return (c_il ? longint'(c_h / 2) : longint'(c_h)) * bytes_per_line();
	endfunction

	// find the next non-empty line and load its address, or stop on a bound error
	function automatic void start_line();
		longint unsigned len, rem, tgt;
		while (s_cur < s_lines && s_cur < 3) begin
			len = lt_len[s_cur];
			rem = s_plen > s_cons ? s_plen - s_cons : 0;
			if (len > rem) begin
				s_err = rvd_pkg::ST_PKT; s_ph = rvd_pkg::PH_DROP; return;
			end
			tgt = bytes_per_line() * lt_line[s_cur]
				+ ((longint'(lt_off[s_cur]) * c_spp * c_dep) >> 3);
			if (tgt + len > frame_size()) begin
				s_err = rvd_pkg::ST_FRAME; s_ph = rvd_pkg::PH_DROP; return;
			end
			if (len == 0) begin
				s_cur++; continue;
			end
			s_wp = tgt[rvd_pkg::ADDR_W-1:0];
			s_left = len;
			s_ph = rvd_pkg::PH_DATA;
			return;
		end
		s_ph = rvd_pkg::PH_DROP;
	endfunction

	// decode one complete 6-byte line header
	function automatic void close_header();
		int unsigned len, fld, ln, cnt, off;
		len = {s_hdr[0], s_hdr[1]};
		fld = s_hdr[2][7];
		ln  = {s_hdr[2][6:0], s_hdr[3]};
		cnt = s_hdr[4][7];
		off = {s_hdr[4][6:0], s_hdr[5]};
		s_hidx = 0;
		if (fld && !c_il) begin
			s_err = rvd_pkg::ST_FIELD; s_ph = rvd_pkg::PH_DROP; return;
		end
		if (ln > s_high) s_high = ln;
		if (s_lines >= rvd_pkg::MAX_LINES) begin
			s_err = rvd_pkg::ST_LINES; s_ph = rvd_pkg::PH_DROP; return;
		end
		lt_len[s_lines] = len; lt_line[s_lines] = ln; lt_off[s_lines] = off;
		s_lines++;
		if (cnt && s_cons < s_plen) return;
		s_cur = 0;
		start_line();
	endfunction

	// work out the result that one payload byte produces
	function automatic rvd_pkg::out_item_t depacketize(rvd_pkg::in_item_t it);
		rvd_pkg::out_item_t r;
		r = '0;
		if (it.first_byte) begin
			if (!s_tsseen) begin
				s_tsseen = 1; s_lts = it.rtp_timestamp;
			end else if (it.rtp_timestamp != s_lts) begin
				s_lts = it.rtp_timestamp; s_frames++; r.frame_start = 1;
			end
			s_plen = it.payload_length; s_seq = it.rtp_sequence;
			s_cons = 0; s_hidx = 0; s_lines = 0; s_cur = 0; s_left = 0; s_err = 0; s_esn = 0;
			if (it.payload_length < rvd_pkg::SHORT_LEN) begin
				s_err = rvd_pkg::ST_SHORT; s_ph = rvd_pkg::PH_DROP;
			end else s_ph = rvd_pkg::PH_ESN;
		end
		if (s_ph != rvd_pkg::PH_IDLE) begin
			if (s_cons < rvd_pkg::MAX_PAYLOAD) s_cons++;
			case (s_ph)
				rvd_pkg::PH_ESN: begin
					s_esn = ((s_esn << 8) | it.payload_byte) & 16'hFFFF;
					s_hidx++;
					if (s_hidx >= 2) begin
						s_hidx = 0;
						s_ph = c_en ? rvd_pkg::PH_HEADER : rvd_pkg::PH_DROP;
					end
				end
				rvd_pkg::PH_HEADER: begin
					s_hdr[s_hidx] = it.payload_byte;
					s_hidx++;
					if (s_hidx >= 6) close_header();
				end
				rvd_pkg::PH_DATA: begin
					r.write_enable = 1; r.write_address = s_wp; r.write_data = it.payload_byte;
					s_wp = s_wp + 1'b1;
					if (s_left > 0) s_left--;
					if (s_left == 0) begin
						s_cur++; start_line();
					end
				end
				default: ;
			endcase
			if (it.last_byte) begin
				r.packet_end = 1;
				if (s_err == 0 && (s_ph == rvd_pkg::PH_ESN || s_ph == rvd_pkg::PH_HEADER ||
						s_ph == rvd_pkg::PH_DATA))
					s_err = rvd_pkg::ST_PKT;
				r.status = s_err[2:0];
				r.full_sequence = s_err == rvd_pkg::ST_SHORT ? 32'd0 : {s_esn[15:0], s_seq[15:0]};
				s_ph = rvd_pkg::PH_IDLE;
			end
		end
		r.frames_total = s_frames;
		r.top_line = s_high[14:0];
		return r;
	endfunction

	task automatic check_field(string nm, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$error("%s: expected 0x%0h, got 0x%0h", nm, e, a);
			fails++;
		end
	endtask

	// monitor: predict accepted bytes, compare accepted results
	always @(posedge clk) begin
		rvd_pkg::out_item_t e;
		in_taken = item_valid && item_ready;
		out_taken = result_valid && result_ready;
		if (in_taken) beat_q.push_back(depacketize(item));
		if (out_taken) begin
			if (beat_q.size() == 0) begin
				$error("result transaction with nothing expected");
				fails++;
			end else begin
				e = beat_q.pop_front();
				check_field("write_enable", e.write_enable, result.write_enable);
				check_field("write_address", e.write_address, result.write_address);
				check_field("write_data", e.write_data, result.write_data);
				check_field("frame_start", e.frame_start, result.frame_start);
				check_field("frames_total", e.frames_total, result.frames_total);
				check_field("packet_end", e.packet_end, result.packet_end);
				check_field("full_sequence", e.full_sequence, result.full_sequence);
				check_field("status", e.status, result.status);
				check_field("top_line", e.top_line, result.top_line);
			end
		end
	end

	// driver: offer queued bytes with random gaps
	always @(negedge clk) begin
		bit v;
		v = item_valid;
		if (arst_n) begin
			if (in_taken) begin
				v = 0;
				if ($urandom_range(0, 40) == 0) tx_burst = ~tx_burst;
				tx_gap = tx_burst ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0);
			end
			if (!v) begin
				if (tx_gap > 0) tx_gap--;
				else if (byte_q.size() > 0) begin
					item <= byte_q.pop_front();
					v = 1;
				end
			end
		end
		item_valid <= v;
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0; rx_hold = LONG_HOLD;
		end
		if (out_taken) begin
			if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
			rx_gap = rx_burst ? 0 : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0);
		end
		if (!arst_n) result_ready <= 1'b0;
		else if (rx_hold > 0) begin
			rx_hold--; result_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--; result_ready <= 1'b0;
		end else result_ready <= 1'b1;
	end

	task automatic reg_write(logic [2:0] idx, int unsigned val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			rvd_pkg::REG_DECODE_ENABLE: c_en = val & 1;
			rvd_pkg::REG_WIDTH_PIXELS:  c_w = val & 16'h3FFF;
			rvd_pkg::REG_HEIGHT_LINES:  c_h = val & 16'h1FFF;
			rvd_pkg::REG_INTERLACED:    c_il = val & 1;
			rvd_pkg::REG_SMP_PER_PIX:   c_spp = val & 7;
			rvd_pkg::REG_BIT_DEPTH:     c_dep = val & 31;
			default: ;
		endcase
	endtask

	task automatic set_format(int unsigned en, int unsigned w, int unsigned h, int unsigned il,
			int unsigned spp, int unsigned dep);
		reg_write(rvd_pkg::REG_DECODE_ENABLE, en);
		reg_write(rvd_pkg::REG_WIDTH_PIXELS, w);
		reg_write(rvd_pkg::REG_HEIGHT_LINES, h);
		reg_write(rvd_pkg::REG_INTERLACED, il);
		reg_write(rvd_pkg::REG_SMP_PER_PIX, spp);
		reg_write(rvd_pkg::REG_BIT_DEPTH, dep);
	endtask

	// hold until every queued byte is taken and every result has come back
	task automatic drain();
		while (byte_q.size() > 0 || item_valid || beat_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// build one packet of the given kind and queue its bytes
	task automatic queue_packet(int kind);
		logic [7:0]  b[$];
		int unsigned n, len, ln, off, fld, hb, lb, offb, cut, plen, bad;
		int unsigned llen[3];
		logic [15:0] seq;
		bit          trail, nolast;
		rvd_pkg::in_item_t it;
		if ($urandom_range(0, 3) == 0) ts_cur = $urandom;
		seq = $urandom;
		trail = 0; nolast = 0;
		if (kind == K_STRAY) begin
			repeat ($urandom_range(1, 3)) begin
				it = '0;
				it.payload_byte = $urandom; it.last_byte = $urandom;
				it.payload_length = $urandom; it.rtp_timestamp = $urandom;
				it.rtp_sequence = $urandom;
				byte_q.push_back(it);
			end
			return;
		end
		if (kind == K_SHORT) begin
			repeat ($urandom_range(1, 7)) b.push_back($urandom);
		end else begin
			b.push_back($urandom); b.push_back($urandom);
			n = kind == K_MANY ? 4 : $urandom_range(1, 3);
			hb = c_il ? c_h / 2 : c_h;
			lb = bytes_per_line();
			bad = $urandom_range(0, n - 1);
			for (int i = 0; i < n; i++) begin
				len = $urandom_range(0, 24);
				if ($urandom_range(0, 9) == 0) len = 0;
				ln = hb > 0 ? $urandom_range(0, hb - 1) : 0;
				off = $urandom_range(0, 3);
				offb = (off * c_spp * c_dep) >> 3;
				if (offb + len > lb) begin
					off = 0; if (len > lb) len = lb;
				end
				fld = c_il ? $urandom_range(0, 1) : 0;
				if (i == bad) begin
					if (kind == K_FIELD) fld = 1;
					if (kind == K_LONGLINE) len = $urandom_range(200, 65535);
					if (kind == K_PASTFRM) ln = $urandom_range(hb, 32767);
				end
				if (i < 3) llen[i] = len;
				b.push_back(len[15:8]); b.push_back(len[7:0]);
				b.push_back({fld[0], ln[14:8]}); b.push_back(ln[7:0]);
				b.push_back({i < n - 1, off[14:8]}); b.push_back(off[7:0]);
			end
			for (int i = 0; i < n && i < 3; i++)
				if (!(kind == K_LONGLINE && i == bad))
					repeat (llen[i]) b.push_back($urandom);
			if ($urandom_range(0, 5) == 0) trail = 1;
			if (trail) repeat ($urandom_range(1, 4)) b.push_back($urandom);
			if (kind == K_TRUNC) begin
				cut = $urandom_range(1, b.size());
				while (b.size() > cut) void'(b.pop_back());
				nolast = $urandom_range(0, 3) == 0;
			end
		end
		plen = b.size();
		if (kind == K_OK && $urandom_range(0, 7) == 0) plen = $urandom_range(plen, 16383);
		if (kind == K_OK && $urandom_range(0, 15) == 0) plen = 16383;
		foreach (b[i]) begin
			it.payload_byte = b[i];
			it.first_byte = i == 0;
			it.last_byte = (i == b.size() - 1) && !nolast;
			it.payload_length = plen;
			it.rtp_timestamp = ts_cur;
			it.rtp_sequence = seq;
			byte_q.push_back(it);
			pushed++;
		end
	endtask

	task automatic random_traffic(int goal);
		int pick;
		while (pushed < goal) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) queue_packet(K_OK);
			else if (pick == 11) queue_packet(K_SHORT);
			else if (pick == 12) queue_packet(K_FIELD);
			else if (pick == 13) queue_packet(K_MANY);
			else if (pick < 16) queue_packet(K_TRUNC);
			else if (pick == 16) queue_packet(K_LONGLINE);
			else if (pick == 17) queue_packet(K_PASTFRM);
			else queue_packet(K_STRAY);
		end
	endtask

	initial begin
		c_en = 1; c_w = 1920; c_h = 1080; c_il = 0; c_spp = 2; c_dep = 10;
		s_ph = rvd_pkg::PH_IDLE; s_hidx = 0; s_cons = 0; s_esn = 0; s_lines = 0; s_cur = 0;
		s_left = 0; s_high = 0; s_err = 0; s_plen = 0; s_seq = 0; s_wp = '0;
		s_lts = '0; s_frames = '0; s_tsseen = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: stray, short, clean, field error, too many lines
		queue_packet(K_STRAY);
		queue_packet(K_SHORT);
		queue_packet(K_OK);
		queue_packet(K_FIELD);
		queue_packet(K_MANY);
		drain();
		random_traffic(180);
		drain();

		// narrowest format: one byte per line, one line
		set_format(1, 1, 1, 0, 1, 8);
		random_traffic(330);
		drain();

		// wide format, addresses wrap
		set_format(1, 8192, 4320, 0, 4, 16);
		random_traffic(480);
		drain();

		// interlaced
		set_format(1, 16, 8, 1, 3, 12);
		random_traffic(630);
		drain();

		// decoding off
		set_format(0, 40, 20, 0, 2, 10);
		random_traffic(740);
		drain();

		// back on, long receiver hold-off while bytes keep coming
		set_format(1, 40, 20, 0, 2, 10);
		hold_req = 1;
		random_traffic(ITEM_GOAL);
		drain();

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(12 * 3000000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/rvd_pkg.sv
rtl/rvd_regs.sv
rtl/rvd_dp.sv
rtl/rvd_ctrl.sv
rtl/rfc4175_video_depacketizer.sv
tb/sv/tb_rfc4175_video_depacketizer.sv
